// ===== sv/psd_pkg.sv =====
`default_nettype none
package psd_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH = 4;
  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_SAMPLES_RST = 4'd10;
  localparam logic [CFG_WIDTH-1:0] SAMPLE_TICKS_RST = 16'd20;
  localparam logic [CFG_WIDTH-1:0] STARTUP_TICKS_RST = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] POWER_ON_TICKS_RST = 16'd3000;
  localparam logic [CFG_WIDTH-1:0] MUTE_TICKS_RST = 16'd500;

  localparam logic [2:0] REG_DEBOUNCE_SAMPLES = 3'd0;
  localparam logic [2:0] REG_SAMPLE_TICKS = 3'd1;
  localparam logic [2:0] REG_STARTUP_TICKS = 3'd2;
  localparam logic [2:0] REG_POWER_ON_TICKS = 3'd3;
  localparam logic [2:0] REG_MUTE_TICKS = 3'd4;

  typedef enum logic [2:0] {
    PH_STARTUP = 3'd0,
    PH_OFF = 3'd1,
    PH_POWERING = 3'd2,
    PH_RUNNING = 3'd3,
    PH_WAIT_HOST = 3'd4,
    PH_MUTE_WAIT = 3'd5
  } phase_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] debounce_samples;
    logic [CFG_WIDTH-1:0] sample_ticks;
    logic [CFG_WIDTH-1:0] startup_ticks;
    logic [CFG_WIDTH-1:0] power_on_ticks;
    logic [CFG_WIDTH-1:0] mute_ticks;
  } cfg_t;

  typedef struct packed {
    logic on;
    logic off;
  } switch_req_t;

  typedef struct packed {
    logic relay_on;
    logic amp_muted;
    logic shutdown_request;
    logic [2:0] phase_code;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/psd_debounce.sv =====
`default_nettype none
module psd_debounce
  import psd_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        switch_level,
  input  wire cfg_t        cfg,
  output switch_req_t      req
);

  localparam int unsigned CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  logic                   qualifying, qualifying_next;
  logic                   target_level, target_level_next;
  logic [COUNT_WIDTH-1:0] sample_count, sample_count_next;
  logic [TIMER_WIDTH-1:0] sample_timer, sample_timer_next;
  logic                   last_switch;

  logic [TIMER_WIDTH-1:0] timer_bump;
  logic [CFG_WIDTH-1:0]   spacing;
  logic [COUNT_WIDTH-1:0] need;
  logic                   timer_done;

  assign timer_bump = (sample_timer == TIMER_MAX) ? sample_timer : sample_timer + 1'b1;
  assign spacing = (cfg.sample_ticks == '0) ? CFG_WIDTH'(1) : cfg.sample_ticks;
  assign need = (cfg.debounce_samples == '0) ? COUNT_WIDTH'(1) : cfg.debounce_samples;
  assign timer_done = (CMP_WIDTH'(timer_bump) >= CMP_WIDTH'(spacing)) ||
                      (timer_bump == TIMER_MAX);

  always_comb begin
    qualifying_next = qualifying;
    target_level_next = target_level;
    sample_count_next = sample_count;
    sample_timer_next = sample_timer;
    req = '0;
    if (qualifying) begin
      sample_timer_next = timer_bump;
      if (timer_done) begin
        sample_timer_next = '0;
        if (sample_count >= need) begin
          qualifying_next = 1'b0;
          req.on = ~target_level;
          req.off = target_level;
        end else if (switch_level != target_level) begin
          qualifying_next = 1'b0;
        end else begin
          sample_count_next = sample_count + 1'b1;
        end
      end
    end else if (switch_level != last_switch) begin
      qualifying_next = 1'b1;
      target_level_next = switch_level;
      sample_count_next = COUNT_WIDTH'(1);
      sample_timer_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qualifying <= 1'b0;
      target_level <= 1'b1;
      sample_count <= '0;
      sample_timer <= '0;
      last_switch <= 1'b1;
    end else if (step) begin
      qualifying <= qualifying_next;
      target_level <= target_level_next;
      sample_count <= sample_count_next;
      sample_timer <= sample_timer_next;
      last_switch <= switch_level;
    end
  end

endmodule
`default_nettype wire

// ===== sv/psd_seq.sv =====
`default_nettype none
module psd_seq
  import psd_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        host_running,
  input  wire switch_req_t req,
  input  wire cfg_t        cfg,
  output result_t          result
);

  localparam int unsigned CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  phase_t                 phase, phase_next;
  logic                   pending_on, pending_on_next;
  logic [TIMER_WIDTH-1:0] delay_timer, delay_timer_next;

  logic [CFG_WIDTH-1:0]   limit;
  logic                   wait_done;
  logic [TIMER_WIDTH-1:0] timer_bump;

  always_comb begin
    case (phase)
      PH_STARTUP: limit = cfg.startup_ticks;
      PH_POWERING: limit = cfg.power_on_ticks;
      PH_MUTE_WAIT: limit = cfg.mute_ticks;
      default: limit = '0;
    endcase
  end

  assign wait_done = (CMP_WIDTH'(delay_timer) >= CMP_WIDTH'(limit)) ||
                     (delay_timer == TIMER_MAX);
  assign timer_bump = wait_done ? delay_timer : delay_timer + 1'b1;

  always_comb begin
    phase_next = phase;
    pending_on_next = pending_on;
    delay_timer_next = delay_timer;
    case (phase)
      PH_STARTUP: begin
        delay_timer_next = timer_bump;
        if (wait_done) begin
          phase_next = (pending_on || req.on) ? PH_POWERING : PH_OFF;
          delay_timer_next = '0;
          pending_on_next = 1'b0;
        end else if (req.on) begin
          pending_on_next = 1'b1;
        end
      end
      PH_OFF: begin
        if (req.on) begin
          phase_next = PH_POWERING;
          delay_timer_next = '0;
        end
      end
      PH_POWERING: begin
        delay_timer_next = timer_bump;
        if (wait_done) begin
          phase_next = PH_RUNNING;
          delay_timer_next = '0;
        end
      end
      PH_RUNNING: begin
        if (req.off || !host_running) begin
          phase_next = PH_WAIT_HOST;
          delay_timer_next = '0;
        end
      end
      PH_WAIT_HOST: begin
        if (!host_running) begin
          phase_next = PH_MUTE_WAIT;
          delay_timer_next = '0;
        end
      end
      PH_MUTE_WAIT: begin
        delay_timer_next = timer_bump;
        if (wait_done) begin
          phase_next = PH_OFF;
          delay_timer_next = '0;
        end
      end
      default: begin
        phase_next = PH_OFF;
        delay_timer_next = '0;
      end
    endcase
  end

  always_comb begin
    result.relay_on = 1'b0;
    result.amp_muted = 1'b1;
    result.shutdown_request = 1'b0;
    result.phase_code = phase_next;
    case (phase_next)
      PH_POWERING, PH_RUNNING: begin
        result.relay_on = 1'b1;
        result.amp_muted = 1'b0;
      end
      PH_WAIT_HOST: begin
        result.relay_on = 1'b1;
        result.amp_muted = 1'b0;
        result.shutdown_request = 1'b1;
      end
      PH_MUTE_WAIT: begin
        result.relay_on = 1'b1;
        result.shutdown_request = 1'b1;
      end
      default: begin
        result.relay_on = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STARTUP;
      pending_on <= 1'b0;
      delay_timer <= '0;
    end else if (step) begin
      phase <= phase_next;
      pending_on <= pending_on_next;
      delay_timer <= delay_timer_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/power_sequencer_with_switch_debounce.sv =====
`default_nettype none
// Power sequencer with a debounced toggle switch. Each input transfer is one time tick carrying
// the switch level and the host-running level, and each tick yields exactly one output transfer
// with the relay, mute and shutdown-request drives and the phase code after that tick. A new
// tick is accepted every clock cycle while the output side does not stall; a tick passes through
// an input register and one pass of switch-qualifier and phase logic into the result register,
// which presents the result until it is transferred while the output side does not stall.
// Timers are TIMER_WIDTH bits wide and saturate. The timing registers are written over the APB
// port and should only be changed while no ticks are in flight.
module power_sequencer_with_switch_debounce
  import psd_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  switch_level,
  input  wire logic                  host_running,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       relay_on,
  output logic                       amp_muted,
  output logic                       shutdown_request,
  output logic [2:0]                 phase_code,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0]      prdata,
  output logic                       pready
);

  cfg_t        cfg;
  logic [2:0]  reg_index;
  logic        cfg_write;

  logic        in_full;
  logic        sw_q;
  logic        host_q;
  logic        advance;
  logic        in_take;

  switch_req_t req;
  result_t     result;

  assign pready = 1'b1;
  assign reg_index = paddr[ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= DEBOUNCE_SAMPLES_RST;
      cfg.sample_ticks <= SAMPLE_TICKS_RST;
      cfg.startup_ticks <= STARTUP_TICKS_RST;
      cfg.power_on_ticks <= POWER_ON_TICKS_RST;
      cfg.mute_ticks <= MUTE_TICKS_RST;
    end else if (cfg_write) begin
      case (reg_index)
        REG_DEBOUNCE_SAMPLES: cfg.debounce_samples <= pwdata[COUNT_WIDTH-1:0];
        REG_SAMPLE_TICKS: cfg.sample_ticks <= pwdata[CFG_WIDTH-1:0];
        REG_STARTUP_TICKS: cfg.startup_ticks <= pwdata[CFG_WIDTH-1:0];
        REG_POWER_ON_TICKS: cfg.power_on_ticks <= pwdata[CFG_WIDTH-1:0];
        REG_MUTE_TICKS: cfg.mute_ticks <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DEBOUNCE_SAMPLES: prdata = DATA_WIDTH'(cfg.debounce_samples);
      REG_SAMPLE_TICKS: prdata = DATA_WIDTH'(cfg.sample_ticks);
      REG_STARTUP_TICKS: prdata = DATA_WIDTH'(cfg.startup_ticks);
      REG_POWER_ON_TICKS: prdata = DATA_WIDTH'(cfg.power_on_ticks);
      REG_MUTE_TICKS: prdata = DATA_WIDTH'(cfg.mute_ticks);
      default: prdata = '0;
    endcase
  end

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sw_q <= switch_level;
      host_q <= host_running;
    end
  end

  psd_debounce #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_debounce (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .switch_level(sw_q),
    .cfg(cfg),
    .req(req)
  );

  psd_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .host_running(host_q),
    .req(req),
    .cfg(cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_on <= result.relay_on;
      amp_muted <= result.amp_muted;
      shutdown_request <= result.shutdown_request;
      phase_code <= result.phase_code;
    end
  end

endmodule
`default_nettype wire
